FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also watches the reset release
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/pte_pkg.sv
// Package: types and constants of the plane error scorer
`timescale 1ns / 1ps

package pte_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_X     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_Y     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_Z     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_OFFSET = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ERROR    = 3'd4;

    // Field widths
    localparam int COORD_W = 32;
    localparam int LIMIT_W = 31;
    localparam int SCORE_W = 64;
    localparam int TALLY_W = 21;
    localparam int TALLY_FIELD_MAX = 2097151;

    // Reset values of the plane registers
    localparam logic signed [31:0] NORMAL_Z_RESET  = 32'sd1073741824;
    localparam logic [LIMIT_W-1:0] MAX_ERROR_RESET = 31'd65536;

    // Classified point handed from front to back
    typedef struct packed {
        logic [SCORE_W-1:0] add;
        logic               inlier;
        logic               last;
    } pte_item_t;

    // Finished set result
    typedef struct packed {
        logic [SCORE_W-1:0] total_score;
        logic [TALLY_W-1:0] inlier_total;
    } pte_result_t;

endpackage

FILE: hw/rtl/pte_fifo.sv
// Small first-word-fall-through queue of registers
`timescale 1ns / 1ps

module pte_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    // Advance pointers with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry on a push transfer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: hw/rtl/pte_front.sv
// Front end: plane registers and the pipelined squared-error classifier
`timescale 1ns / 1ps

module pte_front
    import pte_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic signed [COORD_W-1:0] x_coord,
    input  logic signed [COORD_W-1:0] y_coord,
    input  logic signed [COORD_W-1:0] z_coord,
    input  logic                   last_point,
    output logic                   item_push,
    output pte_item_t              item,
    input  logic                   item_full
);

    // Plane registers
    logic signed [31:0]        normal_x_reg;
    logic signed [31:0]        normal_y_reg;
    logic signed [31:0]        normal_z_reg;
    logic signed [31:0]        plane_offset_reg;
    logic        [LIMIT_W-1:0] max_error_reg;

    // Pipeline stages
    logic                      s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                      s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic signed [63:0]        s1_px_reg, s1_py_reg, s1_pz_reg;
    logic signed [31:0]        s1_d_reg;
    logic        [LIMIT_W-1:0] s1_me_reg;
    logic signed [35:0]        s2_dist_reg;
    logic        [61:0]        s2_lim_reg, s3_lim_reg, s4_lim_reg;
    logic        [31:0]        s3_mag_reg;
    logic        [63:0]        s4_err_reg;

    logic                      advance;
    logic signed [65:0]        dist_sum;
    logic        [61:0]        lim_sq;
    logic        [35:0]        dist_abs;
    logic                      below;

    // Whole pipeline stalls when the last stage cannot hand off
    assign advance = !s4_valid_reg || !item_full;
    assign full    = !advance;

    // Write plane registers; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg     <= '0;
            normal_y_reg     <= '0;
            normal_z_reg     <= NORMAL_Z_RESET;
            plane_offset_reg <= '0;
            max_error_reg    <= MAX_ERROR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NORMAL_X:     normal_x_reg     <= cfg_data;
                REG_NORMAL_Y:     normal_y_reg     <= cfg_data;
                REG_NORMAL_Z:     normal_z_reg     <= cfg_data;
                REG_PLANE_OFFSET: plane_offset_reg <= cfg_data;
                REG_MAX_ERROR:    max_error_reg    <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Exact dot product plus offset, rounded half up to Q16.16
    assign dist_sum = 66'(s1_px_reg) + 66'(s1_py_reg) + 66'(s1_pz_reg)
                    + (66'(s1_d_reg) <<< 30) + 66'sd536870912;
    assign lim_sq   = s1_me_reg * s1_me_reg;

    // Magnitude of the distance
    assign dist_abs = s2_dist_reg[35] ? 36'(-s2_dist_reg) : 36'(s2_dist_reg);

    // Classify against the squared limit
    assign below = (s4_err_reg < 64'(s4_lim_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= push;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Advance the payload through the stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // stage 1: three products
            s1_px_reg   <= normal_x_reg * x_coord;
            s1_py_reg   <= normal_y_reg * y_coord;
            s1_pz_reg   <= normal_z_reg * z_coord;
            s1_d_reg    <= plane_offset_reg;
            s1_me_reg   <= max_error_reg;
            s1_last_reg <= last_point;
            // stage 2: distance and squared limit
            s2_dist_reg <= dist_sum[65:30];
            s2_lim_reg  <= lim_sq;
            s2_last_reg <= s1_last_reg;
            // stage 3: saturated magnitude
            s3_mag_reg  <= (|dist_abs[35:32]) ? 32'hFFFF_FFFF : dist_abs[31:0];
            s3_lim_reg  <= s2_lim_reg;
            s3_last_reg <= s2_last_reg;
            // stage 4: squared error
            s4_err_reg  <= s3_mag_reg * s3_mag_reg;
            s4_lim_reg  <= s3_lim_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    assign item_push   = s4_valid_reg;
    assign item.add    = below ? s4_err_reg : 64'(s4_lim_reg);
    assign item.inlier = below;
    assign item.last   = s4_last_reg;

endmodule

FILE: hw/rtl/pte_back.sv
// Back end: saturating score and inlier accumulators
`timescale 1ns / 1ps

module pte_back
    import pte_pkg::*;
#(
    parameter int TALLY_CAP = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    input  pte_item_t   item,
    input  logic        item_empty,
    output logic        item_pop,
    output logic        result_push,
    output pte_result_t result,
    input  logic        result_full
);

    logic [SCORE_W-1:0] score_sum_reg, score_sum_next;
    logic [TALLY_W-1:0] inlier_tally_reg, inlier_tally_next;
    logic [SCORE_W:0]   score_wide;
    logic [SCORE_W-1:0] score_sat;
    logic [TALLY_W-1:0] tally_upd;

    // Hold a closing item until the result queue has room
    assign item_pop    = !item_empty && !(item.last && result_full);
    assign result_push = item_pop && item.last;

    // Saturating updates
    assign score_wide = {1'b0, score_sum_reg} + {1'b0, item.add};
    assign score_sat  = score_wide[SCORE_W] ? '1 : score_wide[SCORE_W-1:0];
    assign tally_upd  = (item.inlier && (inlier_tally_reg < TALLY_W'(TALLY_CAP)))
                      ? inlier_tally_reg + 1'b1 : inlier_tally_reg;

    assign result.total_score  = score_sat;
    assign result.inlier_total = tally_upd;

    // Accumulate, clear after a closing item
    always_comb
    begin
        score_sum_next    = score_sum_reg;
        inlier_tally_next = inlier_tally_reg;
        if (item_pop)
        begin
            if (item.last)
            begin
                score_sum_next    = '0;
                inlier_tally_next = '0;
            end
            else
            begin
                score_sum_next    = score_sat;
                inlier_tally_next = tally_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_sum_reg    <= '0;
            inlier_tally_reg <= '0;
        end
        else
        begin
            score_sum_reg    <= score_sum_next;
            inlier_tally_reg <= inlier_tally_next;
        end
    end

endmodule

FILE: hw/rtl/plane_truncated_error_score.sv
// Top level: truncated squared-error scorer for one candidate plane
`timescale 1ns / 1ps

// Scores a stream of Q16.16 points against the plane held in the configuration
// registers. One point is taken per clock while full is low; the front end is a
// four-stage pipeline (products, rounded distance, saturated magnitude, square)
// that classifies each point against the squared limit, and a four-entry queue
// passes the classified points to the accumulator, which takes one per clock
// unless a last point meets a full result queue. The result of a set (score
// and inlier count, both including the point marked last) enters a two-entry
// result queue as that last point is taken. full rises only when the front
// pipeline cannot hand off, that is when the result queue and the middle queue
// are both backed up. Write the configuration only while no set is in flight.
module plane_truncated_error_score
    import pte_pkg::*;
#(
    parameter int MAX_POINTS = 1048576
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic signed [COORD_W-1:0] x_coord,
    input  logic signed [COORD_W-1:0] y_coord,
    input  logic signed [COORD_W-1:0] z_coord,
    input  logic                      last_point,
    output logic                      empty,
    input  logic                      pop,
    output logic [SCORE_W-1:0]        total_score,
    output logic [TALLY_W-1:0]        inlier_total
);

    localparam int TALLY_CAP   = (MAX_POINTS < TALLY_FIELD_MAX) ? MAX_POINTS : TALLY_FIELD_MAX;
    localparam int ITEM_DEPTH  = 4;
    localparam int RES_DEPTH   = 2;
    localparam int ITEM_W      = $bits(pte_item_t);
    localparam int RES_W       = $bits(pte_result_t);

    logic        item_push, item_full, item_empty, item_pop;
    pte_item_t   item_in, item_head;
    logic [ITEM_W-1:0] item_rdata;
    logic        result_push, result_full;
    pte_result_t result_in, result_head;
    logic [RES_W-1:0]  result_rdata;

    pte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .z_coord    (z_coord),
        .last_point (last_point),
        .item_push  (item_push),
        .item       (item_in),
        .item_full  (item_full)
    );

    // Queue of classified points between front and back
    pte_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (ITEM_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .wdata (item_in),
        .full  (item_full),
        .pop   (item_pop),
        .rdata (item_rdata),
        .empty (item_empty)
    );

    assign item_head = pte_item_t'(item_rdata);

    pte_back #(
        .TALLY_CAP (TALLY_CAP)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_head),
        .item_empty  (item_empty),
        .item_pop    (item_pop),
        .result_push (result_push),
        .result      (result_in),
        .result_full (result_full)
    );

    // Result queue toward the consumer
    pte_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (result_push),
        .wdata (result_in),
        .full  (result_full),
        .pop   (pop),
        .rdata (result_rdata),
        .empty (empty)
    );

    assign result_head  = pte_result_t'(result_rdata);
    assign total_score  = result_head.total_score;
    assign inlier_total = result_head.inlier_total;

endmodule

FILE: hw/rtl/pte_checker.sv
// Port-level checker for the plane error scorer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pte_checker
    import pte_pkg::*;
#(
    parameter int MAX_POINTS = 1048576
) (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [SCORE_W-1:0] total_score,
    input logic [TALLY_W-1:0] inlier_total
);

    localparam int TALLY_CAP = (MAX_POINTS < TALLY_FIELD_MAX) ? MAX_POINTS : TALLY_FIELD_MAX;

    // A waiting result holds until it is transferred
    `ASSERT_CLK(a_result_hold, clk, rst_n, !empty && !pop |=> !empty && $stable(total_score) && $stable(inlier_total), "result changed while waiting")

    // Leaving reset: no result waits and points are taken
    `ASSERT_ALWAYS(a_reset_state, clk, $rose(rst_n) |-> empty && !full, "bad state after reset")

    // Inlier count never passes its cap
    `ASSERT_CLK(a_count_cap, clk, rst_n, !empty |-> inlier_total <= TALLY_W'(TALLY_CAP), "inlier count above cap")

    // No input stall while the result queue is empty
    `ASSERT_CLK(a_no_stall, clk, rst_n, empty |-> !full, "input stalled with empty result queue")

endmodule

bind plane_truncated_error_score pte_checker #(.MAX_POINTS(MAX_POINTS)) u_pte_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .total_score  (total_score),
    .inlier_total (inlier_total)
);
